FILE: hdl/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg: shared types and constants for the pcx rle palette decoder
// widths of the stream fields, command format between front and back,
// register indexes and back-end states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcxd_pkg;

    // field widths
    localparam int COL_W = 15;
    localparam int ROW_W = 16;
    localparam int IDX_W = 8;
    localparam int CNT_W = 6;
    localparam int CLR_W = 8;
    localparam int RGB_W = 3 * CLR_W;
    localparam int CFG_W = 16;

    // defaults for top level parameters
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // stream byte decoding
    localparam logic [1:0]       MARKER_CODE = 2'b11;
    localparam logic [CNT_W-1:0] LITERAL_CNT = CNT_W'(1);

    // request kinds carried on tuser
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_DATA    = 1'b1;

    // configuration register indexes
    localparam logic CFG_BYTES_PER_LINE = 1'b0;
    localparam logic CFG_ROW_COUNT      = 1'b1;

    // reset values of the configuration registers
    localparam logic [COL_W-1:0] BPL_RESET  = COL_W'(1);
    localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(1);

    typedef enum logic [1:0] {
        CMD_PWRITE,
        CMD_PIXELS,
        CMD_MARKER
    } cmd_kind_t;

    // one command queued between front and back
    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
        logic [CNT_W-1:0] count;
    } cmd_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/pcxd_ram.sv
// ----------------------------------------------------------------------------
// pcxd_ram: generic simple dual port ram
// one write port and one read port, read data registered and held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/pcxd_queue.sv
// ----------------------------------------------------------------------------
// pcxd_queue: short command queue between front and back
// register based fifo, one push (while not full) and one pop (while not empty) a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxd_queue
    import pcxd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cmd_t      push_cmd,
    input  wire logic      pop,
    output cmd_t           head_cmd,
    output q_status_t      status
);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.valid = (count_reg != '0);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/pcxd_front.sv
// ----------------------------------------------------------------------------
// pcxd_front: item intake and classification
// turns palette writes, count markers and index bytes into queued commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxd_front
    import pcxd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             req_type,
    input  wire logic [IDX_W-1:0] palette_index,
    input  wire logic [CLR_W-1:0] in_red,
    input  wire logic [CLR_W-1:0] in_green,
    input  wire logic [CLR_W-1:0] in_blue,
    input  wire logic [IDX_W-1:0] data_byte,
    input  wire q_status_t        q_status,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic             accept;
    logic             is_marker;

    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign is_marker = (data_byte[IDX_W-1 -: 2] == MARKER_CODE);

    // classify the accepted item
    always_comb
    begin
        pending_next   = pending_reg;
        run_len_next   = run_len_reg;
        push           = 1'b0;
        push_cmd.kind  = CMD_PIXELS;
        push_cmd.idx   = data_byte;
        push_cmd.rgb   = {in_red, in_green, in_blue};
        push_cmd.count = LITERAL_CNT;
        if (accept)
        begin
            priority if (req_type == REQ_PALETTE)
            begin
                push          = 1'b1;
                push_cmd.kind = CMD_PWRITE;
                push_cmd.idx  = palette_index;
            end
            else if (pending_reg)
            begin
                // index byte after a count marker
                push           = 1'b1;
                push_cmd.count = run_len_reg;
                pending_next   = 1'b0;
                run_len_next   = '0;
            end
            else if (is_marker)
            begin
                // count byte, still queued so the back can check the image end
                push          = 1'b1;
                push_cmd.kind = CMD_MARKER;
                pending_next  = 1'b1;
                run_len_next  = data_byte[CNT_W-1:0];
            end
            else
            begin
                // single literal index
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            run_len_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            run_len_reg <= run_len_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pcxd_back.sv
// ----------------------------------------------------------------------------
// pcxd_back: command execution and pixel output
// writes the palette, tracks column and row, and while the output is not stalled emits one pixel a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxd_back
    import pcxd_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW           = $clog2(PALETTE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             head_cmd,
    input  wire q_status_t        q_status,
    output logic                  pop,
    input  wire logic [COL_W-1:0] bytes_per_line,
    input  wire logic [ROW_W-1:0] row_count,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [COL_W-1:0]      column,
    output logic [ROW_W-1:0]      row,
    output logic [RGB_W-1:0]      rgb,
    output logic                  last_of_run
);

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             done_reg, done_next;
    logic             out_valid_reg, out_valid_next;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [RGB_W-1:0] out_rgb_reg;
    logic             out_last_reg;
    logic             load;
    logic             item_end;
    logic [COL_W-1:0] end_col;
    logic [ROW_W-1:0] row_inc;
    logic             ram_we;
    logic             ram_re;
    logic [RGB_W-1:0] ram_rdata;

    // palette store
    pcxd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_cmd.idx[AW-1:0]),
        .wdata (head_cmd.rgb),
        .re    (ram_re),
        .raddr (head_cmd.idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign row_inc = row_reg + ROW_W'(1);

    // sequencer: next state and control
    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        done_next   = done_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load        = 1'b0;
        item_end    = 1'b0;
        end_col     = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    pop = 1'b1;
                    priority if (head_cmd.kind == CMD_PWRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (done_reg || (row_reg >= row_count))
                    begin
                        // image finished, data is dropped
                        done_next = 1'b1;
                    end
                    else if (head_cmd.kind == CMD_MARKER)
                    begin
                        // count byte alone draws nothing
                        state_next = ST_IDLE;
                    end
                    else if (head_cmd.count == '0)
                    begin
                        item_end = 1'b1;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        remain_next = head_cmd.count;
                        state_next  = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load        = 1'b1;
                    col_next    = col_reg + COL_W'(1);
                    end_col     = col_next;
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        item_end   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // line wrap once the item is finished
        if (item_end && (end_col >= bytes_per_line))
        begin
            col_next = '0;
            row_next = row_inc;
            if (row_inc >= row_count)
            begin
                done_next = 1'b1;
            end
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_rgb_reg  <= ram_rdata;
            out_last_reg <= (remain_reg == CNT_W'(1));
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign column      = out_col_reg;
    assign row         = out_row_reg;
    assign rgb         = out_rgb_reg;
    assign last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (remain_reg != '0))
        else $error("emit state with no pixels left");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("image done flag cleared");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (remain_reg == CNT_W'(1))) |=> (state_reg == ST_IDLE))
        else $error("last pixel did not end the run");
`endif

endmodule

`default_nettype wire

FILE: hdl/pcx_rle_palette_decoder_core.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_core: 8-bit pcx run-length decoder with palette
// path: an accepted item passes the command queue, the idle state (palette read),
// the lookup state and the emit state into the output register; a palette write
// or marker is handled in the idle state alone
// reset: rst_n clears control state and the register defaults at once;
// palette contents stay undefined until written, there is no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_palette_decoder_core
    import pcxd_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input items
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,  // palette_index, in_red, in_green, in_blue, data_byte
    input  wire logic             s_tuser,  // req_type
    // pixel results
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [55:0]           m_tdata,  // column, row, out_red, out_green, out_blue, pad
    output logic                  m_tlast,  // last_of_run
    // configuration
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [COL_W-1:0] bpl_reg;
    logic [ROW_W-1:0] rows_reg;
    q_status_t        q_status;
    logic             push;
    logic             pop;
    cmd_t             push_cmd;
    cmd_t             head_cmd;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [RGB_W-1:0] rgb;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg  <= BPL_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_LINE: bpl_reg  <= cfg_data[COL_W-1:0];
                CFG_ROW_COUNT:      rows_reg <= cfg_data[ROW_W-1:0];
                default:            ;
            endcase
        end
    end

    pcxd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser),
        .palette_index (s_tdata[7:0]),
        .in_red        (s_tdata[15:8]),
        .in_green      (s_tdata[23:16]),
        .in_blue       (s_tdata[31:24]),
        .data_byte     (s_tdata[39:32]),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    pcxd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    pcxd_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_cmd       (head_cmd),
        .q_status       (q_status),
        .pop            (pop),
        .bytes_per_line (bpl_reg),
        .row_count      (rows_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .column         (column),
        .row            (row),
        .rgb            (rgb),
        .last_of_run    (m_tlast)
    );

    // pack pixel fields, blue in the low palette byte
    assign m_tdata = {1'b0, rgb[CLR_W-1:0], rgb[2*CLR_W-1:CLR_W],
                      rgb[RGB_W-1:2*CLR_W], row, column};

endmodule

`default_nettype wire
